### rtl/fps_pkg.sv
// Shared constants, codes and control types of the Fibonacci peak search core.
// Used by the channel interfaces, the controller, the datapath and the top level.
package fps_pkg;

  localparam int MAX_LENGTH = 65536;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = 17;
  localparam int VAL_W      = 31;
  localparam int POS_W      = 16;
  localparam int FIB_W      = 18;
  localparam int BR_W       = 19;
  localparam int EPOCH_W    = 8;
  localparam int RAM_W      = EPOCH_W + VAL_W;
  localparam int CFG_AW     = 2;
  localparam int CFG_DW     = 32;

  localparam logic [CFG_AW-1:0] ADDR_ARRAY_LENGTH = '0;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_REPLY = 1'b1;
  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_PEAK  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIB,
    S_ROUND,
    S_LOOK1,
    S_RD1,
    S_LOOK2,
    S_RD2,
    S_CMP,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  typedef struct packed {
    logic clr_step;
    logic epoch_inc;
    logic epoch_set1;
    logic fib_init;
    logic fib_step;
    logic brk_init;
    logic fib_shrink;
    logic look_first;
    logic look_second;
    logic load_first_ram;
    logic load_second_ram;
    logic load_first_in;
    logic load_second_in;
    logic reply_write;
    logic set_pend;
    logic cmp_update;
    logic out_load;
    logic out_kind;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic epoch_max;
    logic fib_more;
    logic brk_open;
    logic hit;
    logic fs_le1;
    logic out_free;
  } sts_t;

endpackage

### rtl/fps_in_if.sv
// Input request channel of the peak search core: start or probe reply.
// Depends on fps_pkg for the field widths.
interface fps_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [fps_pkg::VAL_W-1:0]  probe_value;

  modport source (output valid, output kind, output probe_value, input ready);
  modport sink   (input valid, input kind, input probe_value, output ready);
endinterface

### rtl/fps_out_if.sv
// Result request channel of the peak search core: probe request or peak answer.
// Depends on fps_pkg for the field widths.
interface fps_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind_out;
  logic [fps_pkg::POS_W-1:0]  position;

  modport source (output valid, output kind_out, output position, input ready);
  modport sink   (input valid, input kind_out, input position, output ready);
endinterface

### rtl/fps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
module fps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fps_ctrl.sv
// Sequencing state machine of the peak search core.
// Depends on fps_pkg; drives datapath commands and reads datapath status.
module fps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  fps_pkg::sts_t sts,
  output fps_pkg::cmd_t cmd
);

  fps_pkg::state_t state_r, state_nxt;
  fps_pkg::phase_t phase_r, phase_nxt;
  logic            resume_r, resume_nxt;
  logic            emit_kind_r, emit_kind_nxt;
  logic            in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fps_pkg::S_CLEAR;
      phase_r     <= fps_pkg::PH_IDLE;
      resume_r    <= 1'b0;
      emit_kind_r <= fps_pkg::KIND_PROBE;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      resume_r    <= resume_nxt;
      emit_kind_r <= emit_kind_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    resume_nxt    = resume_r;
    emit_kind_nxt = emit_kind_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      fps_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt  = resume_r ? fps_pkg::S_FIB : fps_pkg::S_IDLE;
          resume_nxt = 1'b0;
        end
      end
      fps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_kind == fps_pkg::KIND_START) begin
            cmd.fib_init = 1'b1;
            phase_nxt    = fps_pkg::PH_IDLE;
            if (sts.epoch_max) begin
              cmd.epoch_set1 = 1'b1;
              resume_nxt     = 1'b1;
              state_nxt      = fps_pkg::S_CLEAR;
            end else begin
              cmd.epoch_inc = 1'b1;
              state_nxt     = fps_pkg::S_FIB;
            end
          end else begin
            case (phase_r)
              fps_pkg::PH_FIRST: begin
                cmd.reply_write   = 1'b1;
                cmd.load_first_in = 1'b1;
                phase_nxt         = fps_pkg::PH_IDLE;
                state_nxt         = fps_pkg::S_LOOK2;
              end
              fps_pkg::PH_SECOND: begin
                cmd.reply_write    = 1'b1;
                cmd.load_second_in = 1'b1;
                phase_nxt          = fps_pkg::PH_IDLE;
                state_nxt          = fps_pkg::S_CMP;
              end
              default: begin
              end
            endcase
          end
        end
      end
      fps_pkg::S_FIB: begin
        if (sts.fib_more) begin
          cmd.fib_step = 1'b1;
        end else begin
          cmd.brk_init = 1'b1;
          state_nxt    = fps_pkg::S_ROUND;
        end
      end
      fps_pkg::S_ROUND: begin
        if (sts.brk_open) begin
          cmd.fib_shrink = 1'b1;
          state_nxt      = fps_pkg::S_LOOK1;
        end else begin
          emit_kind_nxt = fps_pkg::KIND_PEAK;
          state_nxt     = fps_pkg::S_EMIT;
        end
      end
      fps_pkg::S_LOOK1: begin
        cmd.look_first = 1'b1;
        state_nxt      = fps_pkg::S_RD1;
      end
      fps_pkg::S_RD1: begin
        if (sts.hit) begin
          cmd.load_first_ram = 1'b1;
          state_nxt          = fps_pkg::S_LOOK2;
        end else begin
          cmd.set_pend  = 1'b1;
          phase_nxt     = fps_pkg::PH_FIRST;
          emit_kind_nxt = fps_pkg::KIND_PROBE;
          state_nxt     = fps_pkg::S_EMIT;
        end
      end
      fps_pkg::S_LOOK2: begin
        cmd.look_second = 1'b1;
        state_nxt       = fps_pkg::S_RD2;
      end
      fps_pkg::S_RD2: begin
        if (sts.hit) begin
          cmd.load_second_ram = 1'b1;
          state_nxt           = fps_pkg::S_CMP;
        end else begin
          cmd.set_pend  = 1'b1;
          phase_nxt     = fps_pkg::PH_SECOND;
          emit_kind_nxt = fps_pkg::KIND_PROBE;
          state_nxt     = fps_pkg::S_EMIT;
        end
      end
      fps_pkg::S_CMP: begin
        cmd.cmp_update = 1'b1;
        if (sts.fs_le1) begin
          emit_kind_nxt = fps_pkg::KIND_PEAK;
          state_nxt     = fps_pkg::S_EMIT;
        end else begin
          state_nxt = fps_pkg::S_ROUND;
        end
      end
      fps_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = emit_kind_r;
          state_nxt    = fps_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fps_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/fps_dp.sv
// Datapath of the peak search core: bracket, Fibonacci pair, probe values,
// epoch-tagged value cache and result register. Uses fps_pkg, fps_out_if, fps_ram.
module fps_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [fps_pkg::LEN_W-1:0]    len,
  input  logic [fps_pkg::VAL_W-1:0]    in_value,
  input  fps_pkg::cmd_t                cmd,
  output fps_pkg::sts_t                sts,
  fps_out_if.source                    out_ch
);

  localparam logic signed [fps_pkg::BR_W-1:0] BR_ONE = fps_pkg::BR_W'(1);

  logic [fps_pkg::ADDR_W-1:0]        cnt_r;
  logic [fps_pkg::EPOCH_W-1:0]       epoch_r;
  logic [fps_pkg::FIB_W-1:0]         fs_r, fl_r;
  logic signed [fps_pkg::BR_W-1:0]   lo_r, hi_r, pos_r;
  logic                              oor_r;
  logic [fps_pkg::VAL_W-1:0]         first_r, second_r;
  logic [fps_pkg::ADDR_W-1:0]        pend_r;
  logic                              out_valid_r, out_kind_r;
  logic [fps_pkg::POS_W-1:0]         out_pos_r;

  logic [fps_pkg::LEN_W-1:0]         len_eff;
  logic signed [fps_pkg::BR_W-1:0]   n_br, fs_ext, pos_nxt, ans;
  logic                              oor_nxt;

  logic                              ram_we;
  logic [fps_pkg::ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [fps_pkg::RAM_W-1:0]         ram_wdata, ram_rdata;
  logic [fps_pkg::EPOCH_W-1:0]       rd_epoch;
  logic [fps_pkg::VAL_W-1:0]         rd_val, lk_val;

  always_comb begin
    if (32'(len) > 32'(fps_pkg::MAX_LENGTH)) begin
      len_eff = fps_pkg::LEN_W'(fps_pkg::MAX_LENGTH);
    end else begin
      len_eff = len;
    end
  end

  assign n_br    = $signed(fps_pkg::BR_W'(len_eff));
  assign fs_ext  = $signed(fps_pkg::BR_W'(fs_r));
  assign ans     = lo_r + BR_ONE;
  assign pos_nxt = cmd.look_second ? (hi_r - fs_ext) : (lo_r + fs_ext);
  assign oor_nxt = pos_nxt[fps_pkg::BR_W-1] || (pos_nxt >= n_br);

  assign rd_epoch = ram_rdata[fps_pkg::RAM_W-1 -: fps_pkg::EPOCH_W];
  assign rd_val   = ram_rdata[fps_pkg::VAL_W-1:0];
  assign lk_val   = oor_r ? '0 : rd_val;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    if (cmd.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd.reply_write) begin
      ram_we    = 1'b1;
      ram_waddr = pend_r;
      ram_wdata = {epoch_r, in_value};
    end
  end

  assign ram_raddr = fps_pkg::ADDR_W'($unsigned(pos_nxt));

  fps_ram #(
    .WIDTH(fps_pkg::RAM_W),
    .DEPTH(fps_pkg::MAX_LENGTH)
  ) u_cache (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      epoch_r <= fps_pkg::EPOCH_W'(1);
    end else begin
      if (cmd.clr_step) begin
        cnt_r <= sts.clr_done ? '0 : cnt_r + 1'b1;
      end
      if (cmd.epoch_set1) begin
        epoch_r <= fps_pkg::EPOCH_W'(1);
      end else if (cmd.epoch_inc) begin
        epoch_r <= epoch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fib_init) begin
      fs_r <= '0;
      fl_r <= fps_pkg::FIB_W'(1);
    end else if (cmd.fib_step) begin
      fs_r <= fl_r;
      fl_r <= fs_r + fl_r;
    end else if (cmd.fib_shrink) begin
      fs_r <= fl_r - fs_r;
      fl_r <= fs_r;
    end
    if (cmd.brk_init) begin
      lo_r <= '1;
      hi_r <= $signed(fps_pkg::BR_W'(fl_r)) - BR_ONE;
    end else if (cmd.cmp_update) begin
      if (first_r > second_r) begin
        hi_r <= hi_r - fs_ext;
      end else begin
        lo_r <= lo_r + fs_ext;
      end
    end
    if (cmd.look_first || cmd.look_second) begin
      pos_r <= pos_nxt;
      oor_r <= oor_nxt;
    end
    if (cmd.brk_init) begin
      first_r <= '0;
    end else if (cmd.load_first_ram) begin
      first_r <= lk_val;
    end else if (cmd.load_first_in) begin
      first_r <= in_value;
    end
    if (cmd.load_second_ram) begin
      second_r <= lk_val;
    end else if (cmd.load_second_in) begin
      second_r <= in_value;
    end
    if (cmd.set_pend) begin
      pend_r <= fps_pkg::ADDR_W'($unsigned(pos_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_pos_r  <= (cmd.out_kind == fps_pkg::KIND_PEAK) ? ans[fps_pkg::POS_W-1:0]
                                                         : pos_r[fps_pkg::POS_W-1:0];
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind_out = out_kind_r;
  assign out_ch.position = out_pos_r;

  assign sts.clr_done  = (cnt_r == fps_pkg::ADDR_W'(fps_pkg::MAX_LENGTH - 1));
  assign sts.epoch_max = &epoch_r;
  assign sts.fib_more  = (fl_r < fps_pkg::FIB_W'(len_eff));
  assign sts.brk_open  = (ans < hi_r);
  assign sts.hit       = oor_r || (rd_epoch == epoch_r);
  assign sts.fs_le1    = (fs_r <= fps_pkg::FIB_W'(1));
  assign sts.out_free  = !out_valid_r || out_ch.ready;

endmodule

### rtl/fibonacci_peak_search_core.sv
// Top level of the Fibonacci peak search core: configuration register, controller,
// datapath. Depends on fps_pkg, fps_in_if, fps_out_if, fps_ctrl and fps_dp.
//
// A start request builds the Fibonacci pair at one step per cycle. Each search
// round then runs S_ROUND, S_LOOK1, S_RD1, S_LOOK2, S_RD2 and S_CMP, using the
// single read port of the value cache, when both probes are answered from the
// cache or fall outside the array. A probe that must go out leaves as a probe
// request. A reply to the first probe resumes with the second lookup in the next
// cycle, and a reply to the second probe goes straight to the compare. The cache
// holds an epoch tag with each value, so a start costs no clearing. A clearing
// pass over every cache entry runs after reset and on every 255th start, during
// which no request is accepted while configuration writes are still taken.
module fibonacci_peak_search_core (
  input  logic                        clk,
  input  logic                        rst_n,
  fps_in_if.sink                      in_ch,
  fps_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fps_pkg::CFG_AW-1:0]  paddr,
  input  logic [fps_pkg::CFG_DW-1:0]  pwdata,
  output logic [fps_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  logic [fps_pkg::LEN_W-1:0] len_r;
  fps_pkg::cmd_t             cmd;
  fps_pkg::sts_t             sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= fps_pkg::LEN_W'(1);
    end else if (psel && penable && pwrite && pready
                 && (paddr == fps_pkg::ADDR_ARRAY_LENGTH)) begin
      len_r <= pwdata[fps_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      fps_pkg::ADDR_ARRAY_LENGTH: prdata = fps_pkg::CFG_DW'(len_r);
      default:                    prdata = '0;
    endcase
  end

  fps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fps_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .len      (len_r),
    .in_value (in_ch.probe_value),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

endmodule

### tb/sv/fps_search_checker.sv
`timescale 1ns / 100ps
// Checker for the Fibonacci peak search core: mirrors the search state, predicts every
// probe request and peak answer, and compares results in order. Depends on fps_pkg,
// fps_in_if and fps_out_if.
module fps_search_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  fps_in_if                           in_mon,
  fps_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [fps_pkg::CFG_AW-1:0]  paddr,
  input  logic [fps_pkg::CFG_DW-1:0]  pwdata,
  output int                          fail_count,
  output int                          open_results
);
  import fps_pkg::*;

  typedef enum logic [1:0] {ROUND_TOP, NEED_SECOND, COMPARE} round_step_t;

  typedef struct packed {
    logic             kind_out;
    logic [POS_W-1:0] position;
  } search_result_t;

  search_result_t   expected_results[$];
  search_result_t   oldest;
  logic [LEN_W-1:0] array_length;
  logic [VAL_W-1:0] cached_value [MAX_LENGTH];
  int unsigned      cached_tag [MAX_LENGTH];
  int unsigned      search_tag;
  int               bracket_lo;
  int               bracket_hi;
  int               fib_minor;
  int               fib_major;
  logic [VAL_W-1:0] first_value;
  phase_t           awaiting;
  int               awaited_pos;

  function automatic int usable_length();
    return (array_length > MAX_LENGTH) ? MAX_LENGTH : int'(array_length);
  endfunction

  // A cache entry counts only if it was written during the current search.
  function automatic bit fetch_value(input int pos, output logic [VAL_W-1:0] value);
    value = '0;
    if (pos < 0 || pos >= usable_length())
      return 1'b1;
    if (cached_tag[pos] != search_tag)
      return 1'b0;
    value = cached_value[pos];
    return 1'b1;
  endfunction

  task automatic post_result(input logic kind, input int pos);
    search_result_t entry;
    entry.kind_out = kind;
    entry.position = pos[POS_W-1:0];
    expected_results.push_back(entry);
  endtask

  task automatic request_probe(input phase_t which, input int pos);
    awaiting = which;
    awaited_pos = pos;
    post_result(KIND_PROBE, pos);
  endtask

  task automatic report_peak();
    awaiting = PH_IDLE;
    post_result(KIND_PEAK, bracket_lo + 1);
  endtask

  task automatic advance_search(input round_step_t from, input logic [VAL_W-1:0] second_in);
    round_step_t      at;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] second;
    int               pos;
    int               shrink;
    bit               done;
    at = from;
    second = second_in;
    done = 1'b0;
    while (!done) begin
      case (at)
        ROUND_TOP: begin
          if (bracket_lo + 1 >= bracket_hi) begin
            report_peak();
            done = 1'b1;
          end else begin
            shrink = fib_major - fib_minor;
            fib_major = fib_minor;
            fib_minor = shrink;
            pos = bracket_lo + fib_minor;
            if (!fetch_value(pos, value)) begin
              request_probe(PH_FIRST, pos);
              done = 1'b1;
            end else begin
              first_value = value;
              at = NEED_SECOND;
            end
          end
        end
        NEED_SECOND: begin
          pos = bracket_hi - fib_minor;
          if (!fetch_value(pos, second)) begin
            request_probe(PH_SECOND, pos);
            done = 1'b1;
          end else begin
            at = COMPARE;
          end
        end
        default: begin
          if (first_value > second)
            bracket_hi = bracket_hi - fib_minor;
          else
            bracket_lo = bracket_lo + fib_minor;
          if (fib_minor <= 1) begin
            report_peak();
            done = 1'b1;
          end else begin
            at = ROUND_TOP;
          end
        end
      endcase
    end
  endtask

  task automatic take_request(input logic kind, input logic [VAL_W-1:0] value);
    int n;
    int sum;
    if (kind == KIND_START) begin
      n = usable_length();
      search_tag++;
      fib_minor = 0;
      fib_major = 1;
      while (fib_major < n) begin
        sum = fib_minor + fib_major;
        fib_minor = fib_major;
        fib_major = sum;
      end
      bracket_lo = -1;
      bracket_hi = fib_major - 1;
      first_value = '0;
      advance_search(ROUND_TOP, '0);
    end else if (awaiting != PH_IDLE) begin
      cached_value[awaited_pos] = value;
      cached_tag[awaited_pos] = search_tag;
      if (awaiting == PH_FIRST) begin
        first_value = value;
        advance_search(NEED_SECOND, '0);
      end else begin
        advance_search(COMPARE, value);
      end
    end
  endtask

  task automatic flag_mismatch(input string field, input int want, input int got);
    fail_count++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      array_length = LEN_W'(1);
      search_tag = 1;
      bracket_lo = -1;
      bracket_hi = 0;
      fib_minor = 0;
      fib_major = 1;
      first_value = '0;
      awaiting = PH_IDLE;
      awaited_pos = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_ARRAY_LENGTH)
        array_length = pwdata[LEN_W-1:0];
      if (in_mon.valid && in_mon.ready)
        take_request(in_mon.kind, in_mon.probe_value);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, kind_out %0d position %0d",
                   $time, out_mon.kind_out, out_mon.position);
        end else begin
          oldest = expected_results.pop_front();
          if (out_mon.kind_out !== oldest.kind_out)
            flag_mismatch("kind_out", oldest.kind_out, out_mon.kind_out);
          if (out_mon.position !== oldest.position)
            flag_mismatch("position", oldest.position, out_mon.position);
        end
      end
    end
    open_results = expected_results.size();
  end

endmodule

### tb/sv/fibonacci_peak_search_core_test.sv
`timescale 1ns / 100ps
// Top of the Fibonacci peak search core testbench: clock, reset, length register writes,
// search requests answered with probe replies, and the verdict. Depends on fps_pkg,
// fps_in_if, fps_out_if, fibonacci_peak_search_core and fps_search_checker.
module fibonacci_peak_search_core_test;
  import fps_pkg::*;

  typedef enum logic [2:0] {
    SHAPE_HILL,
    SHAPE_NOISE,
    SHAPE_FLAT,
    SHAPE_RISE,
    SHAPE_FALL
  } shape_t;

  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 135;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  int                fail_count;
  int                open_results;

  fps_in_if  in_ch();
  fps_out_if out_ch();

  logic [POS_W:0]    result_log[$];
  bit                steady;
  bit                search_open;
  bit                fresh_phase;
  int                probe_pos;
  int                item_count;
  int                cur_length;
  shape_t            shape;
  logic [VAL_W-1:0]  level;
  longint            slope;
  int                peak_at;

  fibonacci_peak_search_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fps_search_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      result_log.push_back({out_ch.kind_out, out_ch.position});
  end

  function automatic logic [VAL_W-1:0] value_at(input int pos);
    longint gap;
    longint v;
    case (shape)
      SHAPE_HILL: begin
        gap = (pos > peak_at) ? pos - peak_at : peak_at - pos;
        v = longint'(level) - gap * slope;
      end
      SHAPE_NOISE: v = longint'($urandom) & 64'h7FFF_FFFF;
      SHAPE_FLAT:  v = longint'(level);
      SHAPE_RISE:  v = longint'(pos) * slope;
      default:     v = longint'(level) - longint'(pos) * slope;
    endcase
    if (v < 0)
      v = 0;
    if (v > 64'h7FFF_FFFF)
      v = 64'h7FFF_FFFF;
    return VAL_W'(v);
  endfunction

  // The first search of each phase uses all-zero values, which walks the bracket to its top.
  task automatic choose_shape();
    int span;
    span = (cur_length > MAX_LENGTH) ? MAX_LENGTH : cur_length;
    shape = shape_t'($urandom_range(0, 4));
    level = $urandom_range(0, 1) ? '1 : VAL_W'($urandom);
    case ($urandom_range(0, 3))
      0:       slope = 0;
      1:       slope = 1;
      2:       slope = longint'($urandom_range(2, 5000));
      default: slope = longint'($urandom_range(1 << 20, 1 << 30));
    endcase
    peak_at = (span > 1) ? $urandom_range(0, span - 1) : 0;
    if (fresh_phase) begin
      shape = SHAPE_FLAT;
      level = '0;
      fresh_phase = 1'b0;
    end
  endtask

  // Starts at a falling edge and returns at the falling edge after acceptance.
  task automatic send_request(input logic kind, input logic [VAL_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.probe_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic collect_results(input int count);
    logic [POS_W:0] got;
    int             seen;
    got = '0;
    seen = 0;
    in_ch.valid <= 1'b0;
    while (seen < count) begin
      @(negedge clk);
      while (seen < count && result_log.size() > 0) begin
        got = result_log.pop_front();
        seen++;
      end
    end
    search_open = (got[POS_W] == KIND_PROBE);
    probe_pos = int'(got[POS_W-1:0]);
  endtask

  task automatic issue(input logic kind, input logic [VAL_W-1:0] value);
    bit owed;
    owed = (kind == KIND_START) || search_open;
    send_request(kind, value);
    if (owed) begin
      item_count++;
      collect_results(1);
    end
  endtask

  task automatic run_search();
    issue(KIND_START, VAL_W'($urandom));
    while (search_open)
      issue(KIND_REPLY, value_at(probe_pos));
  endtask

  task automatic drain_results(input int holdoff);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (open_results != 0);
    repeat (holdoff) @(negedge clk);
    result_log.delete();
  endtask

  task automatic set_length(input int len);
    drain_results(64);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_ARRAY_LENGTH;
    pwdata <= CFG_DW'(len);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_length = len;
  endtask

  initial begin
    int len;
    int pick;
    int target;
    bit paused;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_START;
    in_ch.probe_value = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    search_open = 1'b0;
    fresh_phase = 1'b0;
    probe_pos = 0;
    item_count = 0;
    cur_length = 1;
    paused = 1'b0;
    shape = SHAPE_FLAT;
    level = '0;
    slope = 0;
    peak_at = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(KIND_REPLY, '1);
    issue(KIND_START, '0);
    set_length(0);
    issue(KIND_START, '1);
    set_length(4);
    shape = SHAPE_FLAT;
    level = '0;
    run_search();
    set_length(7);
    level = '1;
    issue(KIND_START, '0);
    if (search_open)
      issue(KIND_REPLY, value_at(probe_pos));
    shape = SHAPE_RISE;
    slope = 3;
    issue(KIND_START, '1);
    while (search_open)
      issue(KIND_REPLY, value_at(probe_pos));
    issue(KIND_REPLY, '0);
    set_length(2);
    shape = SHAPE_HILL;
    level = '1;
    slope = 1;
    peak_at = 1;
    run_search();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: len = MAX_LENGTH;
        1: len = 17'h1FFFF;
        2: len = 0;
        3: len = 2;
        4: len = MAX_LENGTH + 1;
        5: len = 1;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 7)
            len = $urandom_range(1, 50);
          else if (pick < 9)
            len = $urandom_range(51, 2000);
          else
            len = $urandom_range(2001, MAX_LENGTH);
        end
      endcase
      set_length(len);
      steady = (ph == 7);
      fresh_phase = 1'b1;
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        if (ph == 9 && !paused && item_count >= target - PHASE_ITEMS / 2) begin
          drain_results(0);
          paused = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (!search_open && pick < 8) begin
          issue(KIND_REPLY, VAL_W'($urandom));
        end else if (search_open && pick >= 4 && pick < 7) begin
          send_request(KIND_REPLY, value_at(probe_pos));
          choose_shape();
          send_request(KIND_START, VAL_W'($urandom));
          item_count += 2;
          collect_results(2);
        end else if (!search_open || pick < 4) begin
          choose_shape();
          if (pick >= 96) begin
            send_request(KIND_START, VAL_W'($urandom));
            send_request(KIND_START, VAL_W'($urandom));
            item_count += 2;
            collect_results(2);
          end else begin
            issue(KIND_START, VAL_W'($urandom));
          end
        end else begin
          issue(KIND_REPLY, value_at(probe_pos));
        end
      end
    end
    steady = 1'b0;

    drain_results(100);
    if (fail_count == 0 && open_results == 0)
      $display("fibonacci_peak_search_core test passed");
    else
      $display("fibonacci_peak_search_core test failed");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("fibonacci_peak_search_core test failed");
    $finish;
  end

endmodule

### sim.f
rtl/fps_pkg.sv
rtl/fps_in_if.sv
rtl/fps_out_if.sv
rtl/fps_ram.sv
rtl/fps_ctrl.sv
rtl/fps_dp.sv
rtl/fibonacci_peak_search_core.sv
tb/sv/fps_search_checker.sv
tb/sv/fibonacci_peak_search_core_test.sv
